>>> src/vwet_pkg.sv
// ----------------------------------------------------------------------------
// vwet_pkg
// Types, constants and helpers shared by the veto window event tagger.
// ----------------------------------------------------------------------------
`default_nettype none

package vwet_pkg;

    // Time stamps are held modulo 2^TIME_WIDTH
    localparam int unsigned TIME_WIDTH = 48;
    localparam int unsigned NUM_TAGS   = 4;
    localparam int unsigned FIFO_DEPTH = 2;

    localparam int unsigned PADDR_W    = 5;
    localparam int unsigned PDATA_W    = 32;

    // Tag slots
    localparam int unsigned TAG_VETO    = 0;
    localparam int unsigned TAG_DEPOSIT = 1;
    localparam int unsigned TAG_TOP     = 2;
    localparam int unsigned TAG_EDGE    = 3;

    // Register reset values
    localparam logic [19:0] VETO_ENERGY_MIN_RST  = 20'd1024;
    localparam logic [7:0]  VETO_HITS_MIN_RST    = 8'd2;
    localparam logic [20:0] BIG_DEPOSIT_MIN_RST  = 21'd10240;
    localparam logic [23:0] WINDOW_TICKS_RST     = 24'd7500;
    localparam logic [6:0]  TOP_LAYER_MIN_RST    = 7'd98;
    localparam logic [6:0]  BOTTOM_LAYER_MAX_RST = 7'd1;
    localparam logic [5:0]  LAST_STRIP_RST       = 6'd24;

    localparam logic OP_HIT   = 1'b0;
    localparam logic OP_CLOSE = 1'b1;

    typedef logic [TIME_WIDTH-1:0] time_t;

    typedef enum logic [2:0] {
        REG_VETO_ENERGY_MIN  = 3'd0,
        REG_VETO_HITS_MIN    = 3'd1,
        REG_BIG_DEPOSIT_MIN  = 3'd2,
        REG_WINDOW_TICKS     = 3'd3,
        REG_TOP_LAYER_MIN    = 3'd4,
        REG_BOTTOM_LAYER_MAX = 3'd5,
        REG_LAST_STRIP       = 3'd6
    } reg_idx_t;

    typedef enum logic [1:0] {
        CLASS_OUTSIDE = 2'd0,
        CLASS_INSIDE  = 2'd1,
        CLASS_TAGGED  = 2'd2
    } class_t;

    typedef struct packed {
        logic [19:0] veto_energy_min;
        logic [7:0]  veto_hits_min;
        logic [20:0] big_deposit_min;
        logic [23:0] window_ticks;
        logic [6:0]  top_layer_min;
        logic [6:0]  bottom_layer_max;
        logic [5:0]  last_strip;
    } cfg_t;

    // One closed event on its way from front to back
    typedef struct packed {
        logic [NUM_TAGS-1:0] fire;
        time_t               now;
    } qent_t;

    // Class of an event against a tag that did not fire on this event
    function automatic class_t classify(input logic seen, input time_t tag,
                                        input time_t now, input logic [23:0] win);
        time_t diff;
        class_t c;
        diff = now - tag;
        if (!seen)
            c = CLASS_OUTSIDE;
        else if (now == tag)
            c = CLASS_TAGGED;
        else if (now < tag)
            c = CLASS_INSIDE;
        else if (diff <= TIME_WIDTH'(win))
            c = CLASS_INSIDE;
        else
            c = CLASS_OUTSIDE;
        return c;
    endfunction

endpackage

`default_nettype wire

>>> src/vwet_if.sv
// ----------------------------------------------------------------------------
// vwet_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface vwet_in_if;
    import vwet_pkg::*;

    logic        valid;
    logic        ready;
    logic        op;
    logic        hit_is_sipm;
    logic [6:0]  hit_layer;
    logic [5:0]  hit_strip;
    time_t       event_time;
    logic [19:0] veto_energy;
    logic [7:0]  veto_hits;
    logic [19:0] sipm_energy;
    logic [19:0] pmt_energy;

    modport source (
        output valid, op, hit_is_sipm, hit_layer, hit_strip, event_time,
               veto_energy, veto_hits, sipm_energy, pmt_energy,
        input  ready
    );
    modport sink (
        input  valid, op, hit_is_sipm, hit_layer, hit_strip, event_time,
               veto_energy, veto_hits, sipm_energy, pmt_energy,
        output ready
    );
endinterface

interface vwet_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] veto_class;
    logic [1:0] deposit_class;
    logic [1:0] top_class;
    logic [1:0] edge_class;

    modport source (
        output valid, veto_class, deposit_class, top_class, edge_class,
        input  ready
    );
    modport sink (
        input  valid, veto_class, deposit_class, top_class, edge_class,
        output ready
    );
endinterface

`default_nettype wire

>>> src/vwet_cfg.sv
// ----------------------------------------------------------------------------
// vwet_cfg
// APB register file holding the thresholds and the window length.
// ----------------------------------------------------------------------------
`default_nettype none

module vwet_cfg (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [vwet_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [vwet_pkg::PDATA_W-1:0]  pwdata,
    output logic      [vwet_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready,
    output vwet_pkg::cfg_t                     cfg
);
    import vwet_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.veto_energy_min  <= VETO_ENERGY_MIN_RST;
            cfg_reg.veto_hits_min    <= VETO_HITS_MIN_RST;
            cfg_reg.big_deposit_min  <= BIG_DEPOSIT_MIN_RST;
            cfg_reg.window_ticks     <= WINDOW_TICKS_RST;
            cfg_reg.top_layer_min    <= TOP_LAYER_MIN_RST;
            cfg_reg.bottom_layer_max <= BOTTOM_LAYER_MAX_RST;
            cfg_reg.last_strip       <= LAST_STRIP_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_VETO_ENERGY_MIN:  cfg_reg.veto_energy_min  <= pwdata[19:0];
                REG_VETO_HITS_MIN:    cfg_reg.veto_hits_min    <= pwdata[7:0];
                REG_BIG_DEPOSIT_MIN:  cfg_reg.big_deposit_min  <= pwdata[20:0];
                REG_WINDOW_TICKS:     cfg_reg.window_ticks     <= pwdata[23:0];
                REG_TOP_LAYER_MIN:    cfg_reg.top_layer_min    <= pwdata[6:0];
                REG_BOTTOM_LAYER_MAX: cfg_reg.bottom_layer_max <= pwdata[6:0];
                REG_LAST_STRIP:       cfg_reg.last_strip       <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_VETO_ENERGY_MIN:  prdata = PDATA_W'(cfg_reg.veto_energy_min);
            REG_VETO_HITS_MIN:    prdata = PDATA_W'(cfg_reg.veto_hits_min);
            REG_BIG_DEPOSIT_MIN:  prdata = PDATA_W'(cfg_reg.big_deposit_min);
            REG_WINDOW_TICKS:     prdata = PDATA_W'(cfg_reg.window_ticks);
            REG_TOP_LAYER_MIN:    prdata = PDATA_W'(cfg_reg.top_layer_min);
            REG_BOTTOM_LAYER_MAX: prdata = PDATA_W'(cfg_reg.bottom_layer_max);
            REG_LAST_STRIP:       prdata = PDATA_W'(cfg_reg.last_strip);
            default:              prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

>>> src/vwet_front.sv
// ----------------------------------------------------------------------------
// vwet_front
// Takes hits and closing items; keeps the sticky layer flags and works
// out which tags fire on a closed event.
// ----------------------------------------------------------------------------
`default_nettype none

module vwet_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    vwet_in_if.sink             in_ch,
    input  wire vwet_pkg::cfg_t cfg,
    input  wire logic           q_full,
    output logic                push,
    output vwet_pkg::qent_t     push_data
);
    import vwet_pkg::*;

    logic        top_flag_reg, top_flag_next;
    logic        edge_flag_reg, edge_flag_next;
    logic        acc;
    logic        hit_top;
    logic        hit_edge;
    logic [20:0] dep_sum;

    assign in_ch.ready = !q_full;
    assign acc         = in_ch.valid && in_ch.ready;
    assign push        = acc && (in_ch.op == OP_CLOSE);

    assign hit_top  = in_ch.hit_layer >= cfg.top_layer_min;
    assign hit_edge = hit_top
                   || (in_ch.hit_layer <= cfg.bottom_layer_max)
                   || (in_ch.hit_strip == 6'd0)
                   || (in_ch.hit_strip == cfg.last_strip);

    assign dep_sum = {1'b0, in_ch.sipm_energy} + {1'b0, in_ch.pmt_energy};

    always_comb
    begin
        push_data.now               = in_ch.event_time;
        push_data.fire[TAG_VETO]    = (in_ch.veto_energy >= cfg.veto_energy_min)
                                   || (in_ch.veto_hits >= cfg.veto_hits_min);
        push_data.fire[TAG_DEPOSIT] = dep_sum >= cfg.big_deposit_min;
        push_data.fire[TAG_TOP]     = top_flag_reg;
        push_data.fire[TAG_EDGE]    = edge_flag_reg;
    end

    always_comb
    begin
        top_flag_next  = top_flag_reg;
        edge_flag_next = edge_flag_reg;
        if (acc)
        begin
            if (in_ch.op == OP_CLOSE)
            begin
                top_flag_next  = 1'b0;
                edge_flag_next = 1'b0;
            end
            else if (in_ch.hit_is_sipm)
            begin
                top_flag_next  = top_flag_reg  || hit_top;
                edge_flag_next = edge_flag_reg || hit_edge;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_flag_reg  <= 1'b0;
            edge_flag_reg <= 1'b0;
        end
        else
        begin
            top_flag_reg  <= top_flag_next;
            edge_flag_reg <= edge_flag_next;
        end
    end

endmodule

`default_nettype wire

>>> src/vwet_fifo.sv
// ----------------------------------------------------------------------------
// vwet_fifo
// Short queue of closed events between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module vwet_fifo (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire vwet_pkg::qent_t push_data,
    input  wire logic            pop,
    output vwet_pkg::qent_t      pop_data,
    output logic                 full,
    output logic                 empty
);
    import vwet_pkg::*;

    localparam int unsigned PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

    qent_t              mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign full     = cnt_reg == CNT_W'(FIFO_DEPTH);
    assign empty    = cnt_reg == '0;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + CNT_W'(1);
            2'b01:   cnt_next = cnt_reg - CNT_W'(1);
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            cnt_reg <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue read while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(FIFO_DEPTH))
        else $error("queue count beyond depth");

endmodule

`default_nettype wire

>>> src/vwet_back.sv
// ----------------------------------------------------------------------------
// vwet_back
// Holds the tag times, classifies each closed event and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module vwet_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire vwet_pkg::cfg_t  cfg,
    input  wire logic            q_empty,
    input  wire vwet_pkg::qent_t q_data,
    output logic                 pop,
    vwet_out_if.source           out_ch
);
    import vwet_pkg::*;

    time_t               tag_time_reg [NUM_TAGS];
    logic [NUM_TAGS-1:0] tag_seen_reg, tag_seen_next;
    class_t              cls_reg [NUM_TAGS];
    class_t              cls_next [NUM_TAGS];
    logic                out_valid_reg;

    assign pop = !q_empty && (!out_valid_reg || out_ch.ready);

    // A tag that fires takes this event's time, so it is always TAGGED
    always_comb
    begin
        for (int k = 0; k < NUM_TAGS; k++)
        begin
            if (q_data.fire[k])
                cls_next[k] = CLASS_TAGGED;
            else
                cls_next[k] = classify(tag_seen_reg[k], tag_time_reg[k],
                                       q_data.now, cfg.window_ticks);
        end
        tag_seen_next = tag_seen_reg | q_data.fire;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            for (int k = 0; k < NUM_TAGS; k++)
            begin
                cls_reg[k] <= cls_next[k];
                if (q_data.fire[k])
                    tag_time_reg[k] <= q_data.now;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_seen_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
                tag_seen_reg <= tag_seen_next;
            if (pop)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.veto_class    = cls_reg[TAG_VETO];
    assign out_ch.deposit_class = cls_reg[TAG_DEPOSIT];
    assign out_ch.top_class     = cls_reg[TAG_TOP];
    assign out_ch.edge_class    = cls_reg[TAG_EDGE];

    a_fire_tagged: assert property (@(posedge clk) disable iff (!rst_n)
        pop && q_data.fire[TAG_VETO] |=> out_ch.veto_class == CLASS_TAGGED)
        else $error("fired veto tag not reported as tagged");

    a_seen_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        pop && q_data.fire[TAG_EDGE] |=> tag_seen_reg[TAG_EDGE])
        else $error("edge tag not marked seen after firing");

    a_unseen_outside: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !tag_seen_reg[TAG_TOP] && !q_data.fire[TAG_TOP]
        |=> out_ch.top_class == CLASS_OUTSIDE)
        else $error("never fired top tag not reported outside");

endmodule

`default_nettype wire

>>> src/veto_window_event_tagger_top.sv
// ----------------------------------------------------------------------------
// veto_window_event_tagger_top
// Tags detector events against veto, large deposit, top layer and edge
// layer activity and reports each against its veto window.
// ----------------------------------------------------------------------------
//
//   channel   dir  handshake          carries
//   --------  ---  -----------------  ---------------------------------------
//   in_ch     in   valid/ready        hit item (op=0) or closing item (op=1)
//   out_ch    out  valid/ready        four 2-bit classes, one per tag
//   APB       in   psel/penable       threshold and window registers
//
// One item per cycle sustained while the queue is not full. A closing item
// reaches out_ch via the queue and the output register; hit items give
// no transaction. The front compares the energies in the accept cycle;
// the back does four 48-bit subtract-and-compare checks against the stored
// tag times. A two-entry queue decouples the two sides: in_ch stalls only
// when the queue is full, which needs out_ch held stalled.
// rst_n (async, active low) clears flags, seen bits, queue and output valid,
// and loads the register defaults; tag times are left unset.
// ----------------------------------------------------------------------------
`default_nettype none

module veto_window_event_tagger_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    vwet_in_if.sink                            in_ch,
    vwet_out_if.source                         out_ch,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [vwet_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [vwet_pkg::PDATA_W-1:0]  pwdata,
    output logic      [vwet_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready
);
    import vwet_pkg::*;

    cfg_t  cfg;
    logic  push, pop, q_full, q_empty;
    qent_t push_data, pop_data;

    // Register file; write only while the datapath is idle (a rule on the user, unenforced here)
    vwet_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Front: sticky layer flags, tag firing decision per closed event
    vwet_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cfg       (cfg),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    // Closed events in order, fire bits plus time stamp
    vwet_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    // Back: tag time store and window classification, output register
    vwet_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .q_empty (q_empty),
        .q_data  (pop_data),
        .pop     (pop),
        .out_ch  (out_ch)
    );

endmodule

`default_nettype wire
